// ===== src/trd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the run-length pixel decoder
// ---------------------------------------------------------------------------
package trd_pkg;

  localparam int COUNT_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_BYTES  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_PIXELS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_BYTES = 2'd2;

  localparam logic [2:0] PIXEL_BYTES_RESET = 3'd4;
  localparam logic [2:0] PIXEL_BYTES_MIN   = 3'd1;
  localparam logic [2:0] PIXEL_BYTES_MAX   = 3'd4;

  localparam int RUN_FLAG_BIT = 7;
  localparam logic [6:0] LEN_MASK = 7'h7f;

  typedef enum logic {
    KIND_FEED = 1'b0,
    KIND_PULL = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_BYTE_OK  = 3'd0,
    ST_PIXEL    = 3'd1,
    ST_BUSY     = 3'd2,
    ST_NO_PIXEL = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] pixel_word;
    logic        last_pixel;
  } result_t;

  typedef struct packed {
    logic                     wr_en;
    logic [CFG_IDX_BITS-1:0]  wr_index;
    logic [CFG_DATA_BITS-1:0] wr_data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== src/trd_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_fifo
// small register queue with first-word read from the head entry
// ---------------------------------------------------------------------------
module trd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_valid && !full;
  assign do_rd   = rd_pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/trd_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_front
// input stage: takes items, classifies them and hands them to the queue
// ---------------------------------------------------------------------------
module trd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode,
  input  wire logic [7:0]  data_byte,
  output logic             q_push,
  output trd_pkg::cmd_t    q_cmd,
  input  wire logic        q_full
);
  import trd_pkg::*;

  logic valid;
  cmd_t cmd;
  logic accept;

  assign full   = valid && q_full;
  assign accept = push && !full;
  assign q_push = valid;
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (!q_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind      <= opcode ? KIND_PULL : KIND_FEED;
      cmd.data_byte <= data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/trd_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_core
// back end: packet state, pixel assembly, counters and result forming
// ---------------------------------------------------------------------------
module trd_core #(
  parameter int COUNT_BITS = trd_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire trd_pkg::cfg_wr_t cfg,
  input  wire logic            q_empty,
  input  wire trd_pkg::cmd_t   q_cmd,
  output logic                 q_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output trd_pkg::result_t     res
);
  import trd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;

  // configuration
  logic [2:0]               pixel_bytes;
  logic [CFG_DATA_BITS-1:0] image_pixels;
  logic [CFG_DATA_BITS-1:0] source_bytes;

  // decoder state
  logic                  expect_header;
  logic                  run_packet;
  logic [7:0]            pixels_left;
  logic [1:0]            byte_slot;
  logic [31:0]           pixel_hold;
  logic                  pixel_waiting;
  logic [COUNT_BITS-1:0] pixels_given;
  logic [COUNT_BITS-1:0] bytes_taken;
  logic                  finished;

  logic                  expect_header_next;
  logic                  run_packet_next;
  logic [7:0]            pixels_left_next;
  logic [1:0]            byte_slot_next;
  logic [31:0]           pixel_hold_next;
  logic                  pixel_waiting_next;
  logic [COUNT_BITS-1:0] pixels_given_next;
  logic [COUNT_BITS-1:0] bytes_taken_next;
  logic                  finished_next;

  logic [2:0] size_eff;
  logic       go;
  result_t    res_c;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    if (pixel_bytes < PIXEL_BYTES_MIN) begin
      size_eff = PIXEL_BYTES_MIN;
    end else if (pixel_bytes > PIXEL_BYTES_MAX) begin
      size_eff = PIXEL_BYTES_MAX;
    end else begin
      size_eff = pixel_bytes;
    end
  end

  assign go       = !q_empty && !res_full;
  assign q_pop    = go;
  assign res_push = go;

  always_comb begin
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    pixels_left_next   = pixels_left;
    byte_slot_next     = byte_slot;
    pixel_hold_next    = pixel_hold;
    pixel_waiting_next = pixel_waiting;
    pixels_given_next  = pixels_given;
    bytes_taken_next   = bytes_taken;
    finished_next      = finished;
    res_c.status       = ST_NO_PIXEL;
    res_c.pixel_word   = '0;
    res_c.last_pixel   = 1'b0;

    case (q_cmd.kind)
      KIND_FEED: begin
        if (finished) begin
          res_c.status = ST_FINISHED;
        end else if (pixel_waiting) begin
          res_c.status = ST_BUSY;
        end else begin
          res_c.status     = ST_BYTE_OK;
          bytes_taken_next = count_up(bytes_taken);
          if (expect_header) begin
            // packet header: run flag and length
            run_packet_next    = q_cmd.data_byte[RUN_FLAG_BIT];
            pixels_left_next   = {1'b0, q_cmd.data_byte[6:0] & LEN_MASK} + 8'd1;
            expect_header_next = 1'b0;
            byte_slot_next     = '0;
            pixel_hold_next    = '0;
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (byte_slot == 2'(i)) begin
                pixel_hold_next[8*i +: 8] = pixel_hold[8*i +: 8] | q_cmd.data_byte;
              end
            end
            if ({1'b0, byte_slot} + 3'd1 >= size_eff) begin
              pixel_waiting_next = 1'b1;
              byte_slot_next     = '0;
            end else begin
              byte_slot_next = byte_slot + 2'd1;
            end
          end
        end
      end
      KIND_PULL: begin
        if (pixel_waiting) begin
          res_c.status      = ST_PIXEL;
          res_c.pixel_word  = pixel_hold;
          pixels_given_next = count_up(pixels_given);
          res_c.last_pixel  = CMP_W'(pixels_given_next) >= CMP_W'(image_pixels);
          pixels_left_next  = pixels_left - 8'd1;
          if (pixels_left_next == 8'd0) begin
            // packet done: back to header, check source end
            pixel_waiting_next = 1'b0;
            pixel_hold_next    = '0;
            expect_header_next = 1'b1;
            if (CMP_W'(bytes_taken) >= CMP_W'(source_bytes)) begin
              finished_next = 1'b1;
            end
          end else if (!run_packet) begin
            pixel_waiting_next = 1'b0;
            pixel_hold_next    = '0;
          end
          if (res_c.last_pixel) begin
            finished_next      = 1'b1;
            pixel_waiting_next = 1'b0;
          end
        end else if (finished) begin
          res_c.status = ST_FINISHED;
        end else begin
          res_c.status = ST_NO_PIXEL;
        end
      end
      default: begin
        res_c.status = ST_NO_PIXEL;
      end
    endcase
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes   <= PIXEL_BYTES_RESET;
      image_pixels  <= '0;
      source_bytes  <= '0;
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      pixels_left   <= '0;
      byte_slot     <= '0;
      pixel_hold    <= '0;
      pixel_waiting <= 1'b0;
      pixels_given  <= '0;
      bytes_taken   <= '0;
      finished      <= 1'b0;
    end else begin
      if (cfg.wr_en) begin
        case (cfg.wr_index)
          REG_PIXEL_BYTES:  pixel_bytes  <= cfg.wr_data[2:0];
          REG_IMAGE_PIXELS: image_pixels <= cfg.wr_data;
          REG_SOURCE_BYTES: source_bytes <= cfg.wr_data;
          default: ;
        endcase
      end
      if (go) begin
        expect_header <= expect_header_next;
        run_packet    <= run_packet_next;
        pixels_left   <= pixels_left_next;
        byte_slot     <= byte_slot_next;
        pixel_hold    <= pixel_hold_next;
        pixel_waiting <= pixel_waiting_next;
        pixels_given  <= pixels_given_next;
        bytes_taken   <= bytes_taken_next;
        finished      <= finished_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/tga_rle_pixel_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length pixel stream decoder with queue style item and result ports
// ---------------------------------------------------------------------------
// Each item is either a feed (opcode 0, one encoded stream byte) or a pull
// (opcode 1, asks for the next decoded pixel), and every item gives exactly
// one result: status, pixel word (first stream byte in bits 7:0) and the
// last-pixel flag. The block takes one item per clock cycle when results
// are popped as fast; that rate is set by the state update of the back
// end, which reads one item from the command queue and writes one result
// into the result queue in the same cycle. An item passes through the
// input register and the command queue before its result is written to
// the result queue, which shows its head entry right after it is written.
// Configuration registers (pixel_bytes, image_pixels, source_bytes at
// indexes 0, 1, 2) are written through wr_en/wr_index/wr_data and should
// only change while the block is idle. There is no clearing pass: the
// block is ready right after reset.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int COUNT_BITS  = trd_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               wr_en,
  input  wire logic [trd_pkg::CFG_IDX_BITS-1:0]   wr_index,
  input  wire logic [trd_pkg::CFG_DATA_BITS-1:0]  wr_data,
  // item side
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               opcode,
  input  wire logic [7:0]                         data_byte,
  // result side
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [2:0]                              status,
  output logic [31:0]                             pixel_word,
  output logic                                    last_pixel
);
  import trd_pkg::*;

  // front to command queue
  logic    fr_push;
  cmd_t    fr_cmd;
  logic    cq_full;
  // command queue to back end
  logic    cq_empty;
  logic    cq_pop;
  logic [$bits(cmd_t)-1:0] cq_rd;
  // back end to result queue
  logic    rq_full;
  logic    rq_push;
  result_t core_res;
  logic [$bits(result_t)-1:0] rq_rd;
  result_t out_res;
  cfg_wr_t cfg;

  assign cfg.wr_en    = wr_en;
  assign cfg.wr_index = wr_index;
  assign cfg.wr_data  = wr_data;

  // input register and classification
  trd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .data_byte (data_byte),
    .q_push    (fr_push),
    .q_cmd     (fr_cmd),
    .q_full    (cq_full)
  );

  // decouples the front from a stalled back end
  trd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_push),
    .wr_data  (fr_cmd),
    .full     (cq_full),
    .rd_pop   (cq_pop),
    .rd_data  (cq_rd),
    .empty    (cq_empty)
  );

  // packet decoding, one item per cycle while the command queue holds an item and the result queue has room
  trd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (cq_empty),
    .q_cmd    (cmd_t'(cq_rd)),
    .q_pop    (cq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res      (core_res)
  );

  // results wait here until popped
  trd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (rq_push),
    .wr_data  (core_res),
    .full     (rq_full),
    .rd_pop   (pop),
    .rd_data  (rq_rd),
    .empty    (empty)
  );

  assign out_res    = result_t'(rq_rd);
  assign status     = out_res.status;
  assign pixel_word = out_res.pixel_word;
  assign last_pixel = out_res.last_pixel;

endmodule
`default_nettype wire

// ===== verif/tga_rle_pixel_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// self-checking bench for the run-length pixel decoder
// ---------------------------------------------------------------------------
// Feeds packet streams (headers, raw and repeated pixels, stray items) through
// the item queue, predicts every result with a cycle-free model of the
// decoder state, and compares each popped result field by field. Both queue
// sides idle at random, the result side holds off long enough to back the
// block up, and the run ends by finishing the image or the source.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  import trd_pkg::*;

  localparam int COUNT_BITS    = COUNT_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;      // settling margin after the last result
  localparam int LONG_HOLD     = 300;    // result side stall that fills the block
  localparam int PHASE_ITEMS   = 240;    // random items per configuration phase
  localparam int DRAIN_LIMIT   = 20000;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block inputs, all known from time zero
  logic                     wr_en     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  wr_index  = '0;
  logic [CFG_DATA_BITS-1:0] wr_data   = '0;
  logic                     push      = 1'b0;
  logic                     opcode    = 1'b0;
  logic [7:0]               data_byte = '0;
  logic                     pop       = 1'b0;

  // block outputs
  logic        full;
  logic        empty;
  logic [2:0]  status;
  logic [31:0] pixel_word;
  logic        last_pixel;

  tga_rle_pixel_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .pixel_word (pixel_word),
    .last_pixel (last_pixel)
  );

  // ------------------------------------------------------------------------
  // decoder state as the bench sees it
  // ------------------------------------------------------------------------
  logic [2:0]            cfg_size   = PIXEL_BYTES_RESET;
  logic [23:0]           cfg_image  = '0;
  logic [23:0]           cfg_source = '0;

  logic                  want_header = 1'b1;  // next fed byte is a packet header
  logic                  in_run      = 1'b0;  // current packet repeats one pixel
  logic [7:0]            left        = '0;    // pixels still to hand out
  logic [1:0]            slot        = '0;    // byte position inside the pixel
  logic [31:0]           hold        = '0;    // pixel being collected
  logic                  waiting     = 1'b0;  // pixel complete, not yet pulled
  logic [COUNT_BITS-1:0] given       = '0;
  logic [COUNT_BITS-1:0] taken       = '0;
  logic                  done        = 1'b0;

  result_t owed_results[$];   // predicted results in item order
  int      mismatch_count = 0;
  int      items_sent     = 0;
  int      idle_pct       = 0;  // chance of a gap before an item or a pop
  int      hold_asks      = 0;
  int      holds_begun    = 0;
  int      stall_left     = 0;

  // effective pixel size: out-of-range settings clamp to 1 or 4
  function automatic logic [2:0] pixel_size();
    if (cfg_size < PIXEL_BYTES_MIN) return PIXEL_BYTES_MIN;
    if (cfg_size > PIXEL_BYTES_MAX) return PIXEL_BYTES_MAX;
    return cfg_size;
  endfunction

  // advance the decoder by one item and return the result it owes
  function automatic result_t decode_step(input kind_t kind, input logic [7:0] b);
    result_t r;
    r = '0;
    r.status = ST_BYTE_OK;
    if (kind == KIND_FEED) begin
      if (done) begin
        r.status = ST_FINISHED;
      end else if (waiting) begin
        r.status = ST_BUSY;
      end else begin
        if (taken != '1) taken = taken + 1'b1;
        if (want_header) begin
          in_run      = b[RUN_FLAG_BIT];
          left        = {1'b0, b[6:0] & LEN_MASK} + 8'd1;
          want_header = 1'b0;
          slot        = '0;
          hold        = '0;
        end else begin
          hold = hold | (32'(b) << (8 * slot));
          // a size change mid-pixel completes it as soon as the count reaches it
          if ({1'b0, slot} + 3'd1 >= pixel_size()) begin
            waiting = 1'b1;
            slot    = '0;
          end else begin
            slot = slot + 2'd1;
          end
        end
      end
    end else begin
      if (waiting) begin
        r.status     = ST_PIXEL;
        r.pixel_word = hold;
        if (given != '1) given = given + 1'b1;
        if (given >= cfg_image) r.last_pixel = 1'b1;
        left = left - 8'd1;
        if (left == 8'd0) begin
          // packet over: the source end is only looked at here
          waiting     = 1'b0;
          hold        = '0;
          want_header = 1'b1;
          if (taken >= cfg_source) done = 1'b1;
        end else if (!in_run) begin
          waiting = 1'b0;
          hold    = '0;
        end
        // image end stops decoding even inside a packet
        if (r.last_pixel) begin
          done    = 1'b1;
          waiting = 1'b0;
        end
      end else if (done) begin
        r.status = ST_FINISHED;
      end else begin
        r.status = ST_NO_PIXEL;
      end
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ------------------------------------------------------------------------
  // result side: pop driver and checker
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else if (hold_asks != holds_begun) begin
      // long hold-off asked for by the back pressure test
      holds_begun <= hold_asks;
      stall_left = LONG_HOLD;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = pick_gap() - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: status %0d pixel_word %h last_pixel %0d",
               status, pixel_word, last_pixel);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (status !== want.status) begin
          $error("field status expected %0d got %0d", want.status, status);
          mismatch_count++;
        end
        if (pixel_word !== want.pixel_word) begin
          $error("field pixel_word expected %h got %h", want.pixel_word, pixel_word);
          mismatch_count++;
        end
        if (last_pixel !== want.last_pixel) begin
          $error("field last_pixel expected %0d got %0d", want.last_pixel, last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // item side helpers
  // ------------------------------------------------------------------------

  // offer one item, hold it until taken, then record what it owes
  task automatic send_item(input kind_t kind, input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    opcode    <= kind;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    owed_results.push_back(decode_step(kind, b));
    items_sent++;
  endtask

  // stop offering and wait until every owed result has been popped
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back; block must be idle
  task automatic program_regs(input logic [2:0] size, input logic [23:0] image,
                              input logic [23:0] source);
    wr_en    <= 1'b1;
    wr_index <= REG_PIXEL_BYTES;
    wr_data  <= CFG_DATA_BITS'(size);
    @(posedge clk);
    wr_index <= REG_IMAGE_PIXELS;
    wr_data  <= image;
    @(posedge clk);
    wr_index <= REG_SOURCE_BYTES;
    wr_data  <= source;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_size   = size;
    cfg_image  = image;
    cfg_source = source;
  endtask

  task automatic feed_pixel();
    repeat (pixel_size()) send_item(KIND_FEED, 8'($urandom));
  endtask

  // a stray item of any kind, sometimes refused, sometimes breaking framing
  task automatic maybe_stray();
    if ($urandom_range(0, 99) < 6)
      send_item(kind_t'($urandom_range(0, 1)), 8'($urandom));
  endtask

  // one well-formed packet with random content, peppered with stray items
  task automatic send_packet();
    int unsigned roll;
    int unsigned count;
    logic        run;
    roll  = $urandom_range(0, 99);
    count = (roll < 85) ? $urandom_range(0, 5) :
            (roll < 98) ? $urandom_range(6, 40) : $urandom_range(41, 127);
    run = 1'($urandom_range(0, 1));
    send_item(KIND_FEED, {run, 7'(count)});
    if (run) begin
      feed_pixel();
      repeat (count + 1) begin
        maybe_stray();
        send_item(KIND_PULL, 8'($urandom));
      end
    end else begin
      repeat (count + 1) begin
        feed_pixel();
        maybe_stray();
        send_item(KIND_PULL, 8'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // hand-picked stream: empty pull, run packet, refused feed, raw packet
  task automatic test_directed_packets();
    program_regs(PIXEL_BYTES_MAX, '1, '1);
    send_item(KIND_PULL, 8'h00);       // nothing decoded yet
    send_item(KIND_FEED, 8'h81);       // run packet of two pixels
    send_item(KIND_FEED, 8'hff);
    send_item(KIND_FEED, 8'h00);
    send_item(KIND_FEED, 8'ha5);
    send_item(KIND_FEED, 8'h5a);
    send_item(KIND_FEED, 8'h3c);       // refused, pixel still waiting
    send_item(KIND_PULL, 8'hff);
    send_item(KIND_PULL, 8'h00);       // second copy ends the packet
    send_item(KIND_PULL, 8'h00);       // nothing waiting again
    send_item(KIND_FEED, 8'h01);       // raw packet of two pixels
    send_item(KIND_FEED, 8'h01);
    send_item(KIND_FEED, 8'h02);
    send_item(KIND_FEED, 8'h04);
    send_item(KIND_FEED, 8'h08);
    send_item(KIND_PULL, 8'h00);
    send_item(KIND_FEED, 8'h10);
    send_item(KIND_FEED, 8'h20);
    send_item(KIND_FEED, 8'h40);
    send_item(KIND_FEED, 8'h80);
    send_item(KIND_PULL, 8'h00);
    wait_idle();
  endtask

  // shrink the pixel size after two of three bytes have been collected
  task automatic test_size_change();
    program_regs(3'd3, '1, '1);
    send_item(KIND_FEED, 8'h00);       // raw packet, one pixel
    send_item(KIND_FEED, 8'h11);
    send_item(KIND_FEED, 8'h22);
    wait_idle();
    program_regs(PIXEL_BYTES_MIN, '1, '1);
    send_item(KIND_FEED, 8'h33);       // completes the pixel at once
    send_item(KIND_PULL, 8'h00);
    wait_idle();
  endtask

  // random packet streams over every pixel size setting, including the
  // out-of-range ones, with and without idling
  task automatic test_random_stream();
    logic [2:0]  sizes[8];
    logic [23:0] image, source;
    int          goal;
    sizes = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
    for (int ph = 0; ph < 8; ph++) begin
      // limits stay far above anything this run can reach
      image  = (ph % 3 == 0) ? 24'hffffff : 24'($urandom_range(24'h100000, 24'hfffffe));
      source = (ph % 3 == 1) ? 24'hffffff : 24'($urandom_range(24'h100000, 24'hfffffe));
      program_regs(sizes[ph], image, source);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 25 : 50;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_packet();
      wait_idle();
    end
  endtask

  // result side stalls for a long stretch while items keep coming
  task automatic test_back_pressure();
    int goal;
    program_regs(3'($urandom_range(1, 4)), '1, '1);
    idle_pct = 0;
    hold_asks <= hold_asks + 1;
    goal = items_sent + 60;
    while (items_sent < goal) send_packet();
    wait_idle();
  endtask

  // end the image or the source; afterwards everything reports finished
  task automatic test_end_of_stream();
    int guard;
    idle_pct = 20;
    if ($urandom_range(0, 1)) begin
      // image size zero: the next pixel pulled is the last one
      program_regs(3'($urandom_range(1, 4)), '0, '0);
    end else begin
      // source already used up: the next packet end stops decoding
      program_regs(3'($urandom_range(1, 4)), '1, '0);
    end
    for (guard = 0; guard < 200 && !done; guard++) send_packet();
    send_item(KIND_FEED, 8'hff);
    send_item(KIND_PULL, 8'h00);
    send_item(KIND_FEED, 8'h00);
    send_item(KIND_PULL, 8'hff);
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int guard;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_packets();
    test_size_change();
    test_random_stream();
    test_back_pressure();
    test_end_of_stream();

    push <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && owed_results.size() != 0; guard++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
